FILE: hdl/skms_pkg.sv
package skms_pkg;

	localparam int unsigned WIN_DEPTH = 8;

	typedef logic [7:0] byte_t;
	typedef byte_t [WIN_DEPTH-1:0] window_t;
	typedef logic [4:0] mode_t;
	typedef logic [3:0] group_size_t;

	typedef enum logic [2:0] {
		KW_NONE     = 3'd0,
		KW_OFF      = 3'd1,
		KW_LIGHT    = 3'd2,
		KW_CLOCK    = 3'd3,
		KW_SPECTRUM = 3'd4
	} kw_t;

	typedef enum logic [1:0] {
		REG_LIGHT_COUNT    = 2'd0,
		REG_CLOCK_COUNT    = 2'd1,
		REG_SPECTRUM_COUNT = 2'd2
	} reg_idx_t;

	localparam logic [23:0] TEXT_OFF      = "OFF";
	localparam logic [39:0] TEXT_LIGHT    = "Light";
	localparam logic [39:0] TEXT_CLOCK    = "Clock";
	localparam logic [63:0] TEXT_SPECTRUM = "Spectrum";

	localparam int unsigned LEN_OFF      = 3;
	localparam int unsigned LEN_LIGHT    = 5;
	localparam int unsigned LEN_CLOCK    = 5;
	localparam int unsigned LEN_SPECTRUM = 8;

	localparam mode_t MODE_OFF   = 5'd0;
	localparam mode_t SPEC_BASE  = 5'd1;
	localparam mode_t SPEC_TOP   = 5'd10;
	localparam mode_t LIGHT_BASE = 5'd11;
	localparam mode_t LIGHT_TOP  = 5'd20;
	localparam mode_t CLOCK_BASE = 5'd21;
	localparam mode_t CLOCK_TOP  = 5'd30;

	typedef struct packed {
		group_size_t light;
		group_size_t clock;
		group_size_t spectrum;
	} group_cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  changed;
		kw_t   kw;
	} result_t;

	// A mode outside the group enters it at its base; inside, it steps up and
	// wraps to the base when it reaches base plus the group size.
	function automatic mode_t step_group(input mode_t mode, input mode_t base,
			input mode_t top, input group_size_t n);
		logic [5:0] nxt;
		logic [5:0] lim;
		nxt = {1'b0, mode} + 6'd1;
		lim = {1'b0, base} + {2'b00, n};
		if (mode < base || mode > top) begin
			return base;
		end
		if (nxt == lim) begin
			return base;
		end
		return nxt[4:0];
	endfunction

endpackage

FILE: hdl/skms_match.sv
module skms_match #(
	parameter int unsigned CNT_W = 7
) (
	input  skms_pkg::window_t    window,
	input  logic [CNT_W-1:0]     count,
	input  skms_pkg::mode_t      mode,
	input  skms_pkg::group_cfg_t cfg,
	output skms_pkg::result_t    result
);
	import skms_pkg::*;

	logic hit_off;
	logic hit_light;
	logic hit_clock;
	logic hit_spectrum;

	assign hit_off      = (window[2:0] == TEXT_OFF) && (count >= CNT_W'(LEN_OFF));
	assign hit_light    = (window[4:0] == TEXT_LIGHT) && (count >= CNT_W'(LEN_LIGHT));
	assign hit_clock    = (window[4:0] == TEXT_CLOCK) && (count >= CNT_W'(LEN_CLOCK));
	assign hit_spectrum = (window[7:0] == TEXT_SPECTRUM) && (count >= CNT_W'(LEN_SPECTRUM));

	always_comb begin
		result.mode    = mode;
		result.changed = 1'b1;
		result.kw      = KW_NONE;
		priority if (hit_off) begin
			result.kw   = KW_OFF;
			result.mode = MODE_OFF;
		end else if (hit_light) begin
			result.kw   = KW_LIGHT;
			result.mode = step_group(mode, LIGHT_BASE, LIGHT_TOP, cfg.light);
		end else if (hit_clock) begin
			result.kw   = KW_CLOCK;
			result.mode = step_group(mode, CLOCK_BASE, CLOCK_TOP, cfg.clock);
		end else if (hit_spectrum) begin
			result.kw   = KW_SPECTRUM;
			result.mode = step_group(mode, SPEC_BASE, SPEC_TOP, cfg.spectrum);
		end else begin
			result.changed = 1'b0;
		end
	end

endmodule

FILE: hdl/serial_keyword_mode_selector.sv
// Channel  Direction  tdata bits (low to high)
// s_       in         rx_byte[7:0]
// m_       out        current_mode[4:0], mode_changed[5], matched_keyword[8:6], zero[15:9]
// cfg_     in         cfg_addr selects the register, cfg_data[3:0] is the group size
//
// One beat in, one beat out; the result is registered, valid in the cycle after the beat.
// The byte window, the count, the mode and the keyword compare all update in the cycle
// of the input beat, so a new byte is taken every cycle while the output is free or drained.
// A stalled output holds its beat and blocks only further input.
// Reset clears the window, the count, the mode to off and the group sizes to ten.
module serial_keyword_mode_selector #(
	parameter int unsigned BUFFER_LIMIT = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // current_mode, mode_changed, matched_keyword
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [3:0]  cfg_data
);
	import skms_pkg::*;

	localparam int unsigned CNT_W = $clog2(BUFFER_LIMIT);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_LIMIT - 1);

	window_t          win_q;
	window_t          win_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_inc;
	mode_t            mode_q;
	group_cfg_t       cfg_q;
	result_t          res;
	result_t          out_q;
	logic             out_valid_q;
	logic             s_accept;

	assign s_tready = !out_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;
	assign win_nxt  = {win_q[WIN_DEPTH-2:0], s_tdata};
	assign cnt_inc  = cnt_q + CNT_W'(1);

	skms_match #(
		.CNT_W(CNT_W)
	) u_match (
		.window(win_nxt),
		.count (cnt_inc),
		.mode  (mode_q),
		.cfg   (cfg_q),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light    <= 4'd10;
			cfg_q.clock    <= 4'd10;
			cfg_q.spectrum <= 4'd10;
		end else if (cfg_we) begin
			if (cfg_addr == REG_LIGHT_COUNT) cfg_q.light <= cfg_data;
			if (cfg_addr == REG_CLOCK_COUNT) cfg_q.clock <= cfg_data;
			if (cfg_addr == REG_SPECTRUM_COUNT) cfg_q.spectrum <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			cnt_q       <= '0;
			mode_q      <= MODE_OFF;
			out_valid_q <= 1'b0;
		end else begin
			if (s_accept) begin
				win_q  <= win_nxt;
				mode_q <= res.mode;
				if (res.changed || cnt_inc >= CNT_LAST) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_inc;
				end
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q.kw, out_q.changed, out_q.mode};

`ifndef SYNTHESIS
	a_cnt_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_LAST)
		else $error("byte count reached the buffer limit");

	a_match_clears_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && res.changed |=> cnt_q == '0)
		else $error("keyword match did not clear the byte count");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.changed == (out_q.kw != KW_NONE)))
		else $error("mode_changed disagrees with matched_keyword");

	a_off_mode: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && res.kw == KW_OFF |=> mode_q == MODE_OFF)
		else $error("OFF keyword did not set the off mode");

	a_mode_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> out_q.mode == mode_q)
		else $error("output mode differs from the mode register");
`endif

endmodule
